// ===== rtl/bpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the barometric pressure compensation block.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int RegCount = 8;
  localparam int AddrW    = 5;

  localparam logic [2:0] RegAc1  = 3'd0;
  localparam logic [2:0] RegAc2  = 3'd1;
  localparam logic [2:0] RegAc3  = 3'd2;
  localparam logic [2:0] RegAc4  = 3'd3;
  localparam logic [2:0] RegAc5  = 3'd4;
  localparam logic [2:0] RegAc6  = 3'd5;
  localparam logic [2:0] RegB1B2 = 3'd6;
  localparam logic [2:0] RegMcMd = 3'd7;

  localparam int QDepth = 4;
  localparam int QPtrW  = 2;

  // Width of both pipelined dividers.
  localparam int DivW   = 34;
  // Width of the side word carried through each divider.
  localparam int DivSW  = 37;

  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic        [15:0] ac4;
    logic        [15:0] ac5;
    logic        [15:0] ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
  } cal_t;

  // Word handed from the front part to the back part.
  typedef struct packed {
    logic [15:0] raw_temp;
    logic [15:0] raw_press;
  } item_t;

endpackage

// ===== rtl/bpc_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_regs
// APB register file holding the calibration coefficients.
// ----------------------------------------------------------------------------
module bpc_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bpc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output bpc_pkg::cal_t             cal
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cal.ac1 <= 16'sd408;
      cal.ac2 <= -16'sd72;
      cal.ac3 <= -16'sd14383;
      cal.ac4 <= 16'd32741;
      cal.ac5 <= 16'd32757;
      cal.ac6 <= 16'd23153;
      cal.b1  <= 16'sd6190;
      cal.b2  <= 16'sd4;
      cal.mc  <= -16'sd8711;
      cal.md  <= 16'sd2868;
    end else if (wr) begin
      unique case (idx)
        bpc_pkg::RegAc1:  cal.ac1 <= pwdata[15:0];
        bpc_pkg::RegAc2:  cal.ac2 <= pwdata[15:0];
        bpc_pkg::RegAc3:  cal.ac3 <= pwdata[15:0];
        bpc_pkg::RegAc4:  cal.ac4 <= pwdata[15:0];
        bpc_pkg::RegAc5:  cal.ac5 <= pwdata[15:0];
        bpc_pkg::RegAc6:  cal.ac6 <= pwdata[15:0];
        bpc_pkg::RegB1B2: begin
          cal.b1 <= pwdata[31:16];
          cal.b2 <= pwdata[15:0];
        end
        bpc_pkg::RegMcMd: begin
          cal.mc <= pwdata[31:16];
          cal.md <= pwdata[15:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[1:0] == 2'b00) begin
      unique case (idx)
        bpc_pkg::RegAc1:  prdata = {16'd0, cal.ac1};
        bpc_pkg::RegAc2:  prdata = {16'd0, cal.ac2};
        bpc_pkg::RegAc3:  prdata = {16'd0, cal.ac3};
        bpc_pkg::RegAc4:  prdata = {16'd0, cal.ac4};
        bpc_pkg::RegAc5:  prdata = {16'd0, cal.ac5};
        bpc_pkg::RegAc6:  prdata = {16'd0, cal.ac6};
        bpc_pkg::RegB1B2: prdata = {cal.b1, cal.b2};
        bpc_pkg::RegMcMd: prdata = {cal.mc, cal.md};
        default:          prdata = 32'd0;
      endcase
    end
  end

endmodule

// ===== rtl/bpc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_front
// Input side: accepts sample pairs and queues them for the datapath.
// ----------------------------------------------------------------------------
module bpc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [15:0]          raw_temp,
  input  logic [15:0]          raw_press,
  output logic                 q_valid,
  input  logic                 q_take,
  output bpc_pkg::item_t       q_item
);

  bpc_pkg::item_t           mem [bpc_pkg::QDepth];
  logic [bpc_pkg::QPtrW-1:0] wp;
  logic [bpc_pkg::QPtrW-1:0] rp;
  logic [bpc_pkg::QPtrW:0]   cnt;
  logic                      push;
  logic                      pop;

  assign in_stall = (cnt == 3'(bpc_pkg::QDepth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt != '0);
  assign pop      = q_valid && q_take;
  assign q_item   = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= '{raw_temp: raw_temp, raw_press: raw_press};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      cnt <= cnt + {2'd0, push} - {2'd0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cnt == 3'(bpc_pkg::QDepth) |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    cnt == '0 |-> !pop) else $error("queue underflow");
  a_count: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> cnt == $past(cnt) + 3'd1) else $error("count slip");

endmodule

// ===== rtl/bpc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Carries a side word along so results stay aligned with their item.
// ----------------------------------------------------------------------------
module bpc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_v,
  input  logic [bpc_pkg::DivW-1:0]  num,
  input  logic [bpc_pkg::DivW-1:0]  den,
  input  logic [bpc_pkg::DivSW-1:0] side_in,
  output logic                      out_v,
  output logic [bpc_pkg::DivW-1:0]  quo,
  output logic [bpc_pkg::DivSW-1:0] side_out
);

  localparam int W  = bpc_pkg::DivW;
  localparam int SW = bpc_pkg::DivSW;

  logic [W-1:0]  n_r [1:W];
  logic [W-1:0]  d_r [1:W];
  logic [W-1:0]  r_r [1:W];
  logic [SW-1:0] s_r [1:W];
  logic          v_r [1:W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W-1:0]  n_in;
    logic [W-1:0]  d_in;
    logic [W-1:0]  r_in;
    logic [SW-1:0] s_in;
    logic          v_in;
    logic [W:0]    trial;
    logic [W:0]    diff;
    if (k == 0) begin : g_first
      assign n_in = num;
      assign d_in = den;
      assign r_in = '0;
      assign s_in = side_in;
      assign v_in = in_v;
    end else begin : g_next
      assign n_in = n_r[k];
      assign d_in = d_r[k];
      assign r_in = r_r[k];
      assign s_in = s_r[k];
      assign v_in = v_r[k];
    end
    assign trial = {r_in, n_in[W-1]};
    assign diff  = trial - {1'b0, d_in};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[W]) begin
          r_r[k+1] <= diff[W-1:0];
          n_r[k+1] <= {n_in[W-2:0], 1'b1};
        end else begin
          r_r[k+1] <= trial[W-1:0];
          n_r[k+1] <= {n_in[W-2:0], 1'b0};
        end
        d_r[k+1] <= d_in;
        s_r[k+1] <= s_in;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) v_r[k+1] <= 1'b0;
      else if (en) v_r[k+1] <= v_in;
    end
  end

  assign out_v    = v_r[W];
  assign quo      = n_r[W];
  assign side_out = s_r[W];

endmodule

// ===== rtl/bpc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_back
// Compensation datapath: temperature stages, signed divide, pressure
// coefficient stages, unsigned divide, final polynomial and saturation.
// The whole pipeline advances together when the output can move.
// ----------------------------------------------------------------------------
module bpc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  bpc_pkg::cal_t        cal,
  input  logic                 q_valid,
  output logic                 q_take,
  input  bpc_pkg::item_t       q_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   temp_tenths,
  output logic [17:0]          pressure_pa,
  output logic                 status
);

  localparam int TW = bpc_pkg::DivW;
  localparam int SW = bpc_pkg::DivSW;

  logic en;
  // Output register frees whenever it is empty or being taken.
  assign en     = !out_valid || !out_stall;
  assign q_take = en;

  // ---- stage A: x1 = ((ut - ac6) * ac5) >> 15
  logic               a_v;
  logic signed [34:0] a_prod;
  logic [15:0]        a_up;
  always_ff @(posedge clk) begin
    if (en) begin
      a_prod <= $signed({1'b0, q_item.raw_temp}) - $signed({1'b0, cal.ac6});
      a_up   <= q_item.raw_press;
    end
  end
  // a_prod holds the difference; stage B multiplies it by ac5
  logic               b_v;
  logic signed [34:0] b_prod;
  logic [15:0]        b_up;
  always_ff @(posedge clk) begin
    if (en) begin
      b_prod <= a_prod * 35'($signed({1'b0, cal.ac5}));
      b_up   <= a_up;
    end
  end
  logic signed [19:0] c_x1;
  logic signed [20:0] c_den;
  logic               c_v;
  logic [15:0]        c_up;
  logic signed [19:0] b_x1;
  assign b_x1 = 20'(b_prod >>> 15);
  always_ff @(posedge clk) begin
    if (en) begin
      c_x1  <= b_x1;
      c_den <= 21'(b_x1) + 21'(cal.md);
      c_up  <= b_up;
    end
  end

  // ---- signed divide mc*2048 / (x1+md), truncating
  logic signed [27:0] mcs;
  logic               nneg;
  logic               dneg;
  logic [TW-1:0]      tnum;
  logic [TW-1:0]      tden;
  assign mcs  = 28'(cal.mc) <<< 11;
  assign nneg = mcs[27];
  assign dneg = c_den[20];
  assign tnum = TW'(nneg ? -mcs : mcs);
  assign tden = TW'(dneg ? -c_den : c_den);

  logic          td_v;
  logic [TW-1:0] td_q;
  logic [SW-1:0] td_s;
  bpc_div u_tdiv (
    .clk(clk), .rst(rst), .en(en), .in_v(c_v),
    .num(tnum), .den(tden),
    .side_in({c_up, (c_den == '0), nneg ^ dneg, c_x1[18:0]}),
    .out_v(td_v), .quo(td_q), .side_out(td_s)
  );

  // ---- stage D: b5, t, b6
  logic signed [27:0] d_b5;
  logic               d_v;
  logic [15:0]        d_up;
  logic               d_err;
  logic signed [27:0] x2q;
  assign x2q = td_s[19] ? -28'(td_q) : 28'(td_q);
  always_ff @(posedge clk) begin
    if (en) begin
      d_b5  <= 28'($signed(td_s[18:0])) + x2q;
      d_up  <= td_s[36:21];
      d_err <= td_s[20];
    end
  end
  logic signed [27:0] d_b6;
  logic signed [27:0] d_tw;
  logic signed [15:0] d_t;
  assign d_b6 = d_b5 - 28'sd4000;
  assign d_tw = (d_b5 + 28'sd8) >>> 4;
  always_comb begin
    if (d_tw > 28'sd32767)       d_t = 16'sh7fff;
    else if (d_tw < -28'sd32768) d_t = 16'sh8000;
    else                         d_t = d_tw[15:0];
  end

  // ---- stage E: b6^2 and per-coefficient products of b6
  logic signed [55:0] e_sq2;
  logic signed [43:0] e_ac2b6;
  logic signed [43:0] e_ac3b6;
  logic signed [15:0] e_t;
  logic               e_v;
  logic [15:0]        e_up;
  logic               e_err;
  always_ff @(posedge clk) begin
    if (en) begin
      e_sq2   <= d_b6 * d_b6;
      e_ac2b6 <= cal.ac2 * d_b6;
      e_ac3b6 <= cal.ac3 * d_b6;
      e_t     <= d_t;
      e_up    <= d_up;
      e_err   <= d_err;
    end
  end
  logic signed [41:0] e_sq;
  assign e_sq = 42'(e_sq2 >>> 12);

  // ---- stage F: b2*sq, b1*sq
  logic signed [57:0] f_b2sq;
  logic signed [57:0] f_b1sq;
  logic signed [32:0] f_x2a;
  logic signed [30:0] f_x1c;
  logic signed [15:0] f_t;
  logic               f_v;
  logic [15:0]        f_up;
  logic               f_err;
  always_ff @(posedge clk) begin
    if (en) begin
      f_b2sq <= cal.b2 * e_sq;
      f_b1sq <= cal.b1 * e_sq;
      f_x2a  <= 33'(e_ac2b6 >>> 11);
      f_x1c  <= 31'(e_ac3b6 >>> 13);
      f_t    <= e_t;
      f_up   <= e_up;
      f_err  <= e_err;
    end
  end

  // ---- stage G: b3, x3 for b4
  logic signed [47:0] g_x3;
  logic signed [47:0] g_b3n;
  logic signed [31:0] g_x3b;
  assign g_x3  = 48'(f_b2sq >>> 11) + 48'(f_x2a);
  assign g_b3n = (48'(cal.ac1) <<< 2) + g_x3 + 48'sd2;
  assign g_x3b = 32'((48'(f_x1c) + 48'(f_b1sq >>> 16) + 48'sd2) >>> 2);

  logic signed [47:0] h_b3;
  logic [31:0]        h_x3u;
  logic signed [15:0] h_t;
  logic               h_v;
  logic [15:0]        h_up;
  logic               h_err;
  always_ff @(posedge clk) begin
    if (en) begin
      // truncating divide by 4
      h_b3  <= (g_b3n < 0) ? -((-g_b3n) >>> 2) : (g_b3n >>> 2);
      h_x3u <= 32'(g_x3b) + 32'd32768;
      h_t   <= f_t;
      h_up  <= f_up;
      h_err <= f_err;
    end
  end

  // ---- stage I: b4 and up - b3
  logic [47:0]        i_b4p;
  logic [31:0]        i_dif;
  logic signed [15:0] i_t;
  logic               i_v;
  logic               i_err;
  always_ff @(posedge clk) begin
    if (en) begin
      i_b4p <= cal.ac4 * h_x3u;
      i_dif <= {16'd0, h_up} - h_b3[31:0];
      i_t   <= h_t;
      i_err <= h_err;
    end
  end
  logic [31:0] i_b4;
  assign i_b4 = {15'd0, i_b4p[31:15]};

  // ---- stage J: b7
  logic [47:0]        j_b7p;
  logic [31:0]        j_b4;
  logic signed [15:0] j_t;
  logic               j_v;
  logic               j_err;
  always_ff @(posedge clk) begin
    if (en) begin
      j_b7p <= i_dif * 16'd50000;
      j_b4  <= i_b4;
      j_t   <= i_t;
      j_err <= i_err || (i_b4 == '0);
    end
  end
  logic [31:0] j_b7;
  logic        j_big;
  logic [31:0] pnum;
  assign j_b7  = j_b7p[31:0];
  assign j_big = j_b7[31];
  assign pnum  = j_big ? j_b7 : {j_b7[30:0], 1'b0};

  // side word: t in [17:2], err in [1], big in [0]
  logic          pd_v;
  logic [TW-1:0] pd_q;
  logic [SW-1:0] pd_s;
  bpc_div u_pdiv (
    .clk(clk), .rst(rst), .en(en), .in_v(j_v),
    .num({2'b00, pnum}), .den({2'b00, j_b4}),
    .side_in({19'd0, j_t, j_err, j_big}),
    .out_v(pd_v), .quo(pd_q), .side_out(pd_s)
  );
  logic [31:0] k_pu;
  assign k_pu = pd_s[0] ? {pd_q[30:0], 1'b0} : pd_q[31:0];

  // ---- stage L: polynomial products
  logic [31:0]        l_p;
  logic [47:0]        l_x1a;
  logic signed [47:0] l_x2;
  logic signed [15:0] l_t;
  logic               l_v;
  logic               l_err;
  logic [23:0]        k_ph;
  assign k_ph = k_pu[31:8];
  always_ff @(posedge clk) begin
    if (en) begin
      l_p   <= k_pu;
      l_x1a <= k_ph * k_ph;
      l_x2  <= -48'sd7357 * $signed({16'd0, k_pu});
      l_t   <= pd_s[17:2];
      l_err <= pd_s[1];
    end
  end
  logic signed [63:0] m_x1p;
  logic signed [32:0] m_x2;
  logic signed [32:0] m_p;
  logic signed [15:0] m_t;
  logic               m_v;
  logic               m_err;
  always_ff @(posedge clk) begin
    if (en) begin
      m_x1p <= $signed({16'd0, l_x1a}) * 64'sd3038;
      m_x2  <= 33'(l_x2 >>> 16);
      m_p   <= $signed({1'b0, l_p});
      m_t   <= l_t;
      m_err <= l_err;
    end
  end
  logic signed [49:0] n_sum;
  logic signed [49:0] n_p;
  assign n_sum = 50'(m_x1p >>> 16) + 50'(m_x2) + 50'sd3791;
  assign n_p   = 50'(m_p) + (n_sum >>> 4);

  logic [17:0]        psat;
  always_comb begin
    if (n_p < 0)                psat = '0;
    else if (n_p > 50'sd262143) psat = 18'h3ffff;
    else                        psat = n_p[17:0];
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0; b_v <= 1'b0; c_v <= 1'b0; d_v <= 1'b0; e_v <= 1'b0;
      f_v <= 1'b0; h_v <= 1'b0; i_v <= 1'b0; j_v <= 1'b0; l_v <= 1'b0;
      m_v <= 1'b0; out_valid <= 1'b0;
    end else if (en) begin
      a_v <= q_valid; b_v <= a_v; c_v <= b_v;
      d_v <= td_v; e_v <= d_v; f_v <= e_v; h_v <= f_v; i_v <= h_v; j_v <= i_v;
      l_v <= pd_v; m_v <= l_v; out_valid <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      temp_tenths <= m_err ? 16'sd0 : m_t;
      pressure_pa <= m_err ? 18'd0 : psat;
      status      <= m_err;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> temp_tenths == 16'sd0 && pressure_pa == 18'd0)
    else $error("error result not zeroed");
  a_take: assert property (@(posedge clk) disable iff (rst)
    q_take |-> !out_valid || !out_stall) else $error("took while blocked");

endmodule

// ===== rtl/barometric_pressure_compensation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Integer compensation of raw barometric temperature and pressure words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with raw_temp and raw_press; one word
//   is taken at each edge where in_valid is high and in_stall low.
//   Output channel: out_valid / out_stall with temp_tenths, pressure_pa and
//   status (1 when a divisor was zero; both values are then zero).
//   Calibration coefficients sit behind an APB port at 4-byte steps; write
//   them only while no word is in flight.
//   Throughput: one word per cycle while out_stall does not freeze the
//   datapath. Depth is set by two 34-stage pipelined dividers plus the
//   multiply stages around them.
//   A four-entry queue sits in front of the datapath; when out_stall holds,
//   the whole datapath freezes and the queue absorbs up to four more words
//   before in_stall rises.
//   Reset (rst, synchronous) empties the queue and pipeline and loads the
//   factory default coefficients.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [15:0]               raw_temp,
  input  logic [15:0]               raw_press,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [15:0]        temp_tenths,
  output logic [17:0]               pressure_pa,
  output logic                      status,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bpc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  bpc_pkg::cal_t  cal;
  bpc_pkg::item_t q_item;
  logic           q_valid;
  logic           q_take;

  bpc_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cal(cal)
  );

  bpc_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .raw_temp(raw_temp), .raw_press(raw_press),
    .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
  );

  bpc_back u_back (
    .clk(clk), .rst(rst), .cal(cal),
    .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
    .out_valid(out_valid), .out_stall(out_stall),
    .temp_tenths(temp_tenths), .pressure_pa(pressure_pa), .status(status)
  );

endmodule
